// ===== design/bfdh_pkg.sv =====
// Shared types, constants and the salt table for the djb2 double-hash Bloom filter.
// No dependencies; every other design file but bfdh_ram refers to it by scoped names.
`default_nettype none

package bfdh_pkg;

    // Bit store size and derived widths
    localparam int MAX_FILTER_BYTES = 8192;
    localparam int ADDR_W  = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
    localparam int BIT_W   = ADDR_W + 3;                       // bit index width
    localparam int NB_W    = $clog2(MAX_FILTER_BYTES + 1);     // clamped byte count width

    // Field widths
    localparam int REQ_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int FB_W    = 14;
    localparam int PC_W    = 8;
    localparam int HASH_W  = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FB_W;

    // Hash constants
    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
    localparam int SALT_LEN  = 14;

    // Remainder unit: full 64-bit pass, or a short pass for sums of already reduced values
    localparam int FULL_STEPS  = HASH_W;
    localparam int SHORT_STEPS = (BIT_W + 1 > PC_W + 1) ? BIT_W + 1 : PC_W + 1;
    localparam int LOAD_SHIFT  = HASH_W - SHORT_STEPS;
    localparam int CNT_W       = $clog2(FULL_STEPS);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_BYTES = 1'b0,
        CFG_PROBE_COUNT  = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SALT,
        ST_MOD_LOAD,
        ST_MOD_RUN,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    // Which operand the remainder unit is reducing
    typedef enum logic [1:0] {
        MS_BIT,     // first probe bit: x mod N
        MS_X,       // (x + y) mod N
        MS_Y        // (y + i) mod N
    } mod_sel_t;

    // "saltygoodness" followed by NUL
    function automatic logic [BYTE_W-1:0] salt_byte(input logic [3:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            4'd0:    b = 8'h73;
            4'd1:    b = 8'h61;
            4'd2:    b = 8'h6c;
            4'd3:    b = 8'h74;
            4'd4:    b = 8'h79;
            4'd5:    b = 8'h67;
            4'd6:    b = 8'h6f;
            4'd7:    b = 8'h6f;
            4'd8:    b = 8'h64;
            4'd9:    b = 8'h6e;
            4'd10:   b = 8'h65;
            4'd11:   b = 8'h73;
            4'd12:   b = 8'h73;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== design/bfdh_if.sv =====
// Valid/ready channel interfaces for key requests and operation results.
// Depends on bfdh_pkg for field widths.
`default_nettype none

interface bfdh_req_if;
    logic                       valid;
    logic                       ready;
    logic [bfdh_pkg::REQ_W-1:0]  req_type;
    logic [bfdh_pkg::BYTE_W-1:0] key_byte;
    logic                       has_byte;
    logic                       last_byte;

    modport source (output valid, req_type, key_byte, has_byte, last_byte, input ready);
    modport sink   (input valid, req_type, key_byte, has_byte, last_byte, output ready);
endinterface

interface bfdh_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [bfdh_pkg::REQ_W-1:0] done_op;
    logic                      maybe_present;

    modport source (output valid, done_op, maybe_present, input ready);
    modport sink   (input valid, done_op, maybe_present, output ready);
endinterface

`default_nettype wire

// ===== design/bfdh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bfdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/bloom_filter_djb2_double_hash_core.sv =====
// Top level of the djb2 double-hash Bloom filter: sequencer, shared adder,
// bit-serial remainder unit and the byte-wide bit store.
// Depends on bfdh_pkg, bfdh_req_if / bfdh_rsp_if and bfdh_ram.
`default_nettype none

// Bloom filter over a bit store of 8*filter_bytes bits (up to 64K bits held in
// an 8192 x 8 RAM). Keys arrive one byte per transfer and fold into a 64-bit
// djb2 hash at one byte per cycle while the block is idle. The transfer
// carrying last_byte starts the operation: the salt is hashed into y, then
// probe_count probes run, each tested or set in the RAM. The probe index math
// goes through one bit-serial remainder unit against N = 8*filter_bytes:
// reductions of raw 64-bit values (the first probe bit and the first x and y
// updates) take the full 64-bit pass, later ones the short pass. A lookup
// stops at the first clear bit, and the emit state stretches while the output
// register still holds an unaccepted result. The request side is not ready
// during an operation. A clear request sweeps the whole RAM, one byte per
// cycle, then returns its result; the same sweep runs after reset with no
// result. One result is returned per lookup, insert or clear through an
// output register, so a finished result can wait for the sink while the next
// key streams in. Configuration writes (filter_bytes, probe_count) are taken
// at any time but should only be issued while idle.
module bloom_filter_djb2_double_hash_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    bfdh_req_if.sink                           req,
    bfdh_rsp_if.source                         rsp,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int HW = bfdh_pkg::HASH_W;
    localparam int BW = bfdh_pkg::BIT_W;
    localparam int AW = bfdh_pkg::ADDR_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    bfdh_pkg::state_t   state_reg, state_next;
    bfdh_pkg::mod_sel_t mod_sel_reg, mod_sel_next;
    bfdh_pkg::req_t     op_reg, op_next;

    logic [HW-1:0]                   key_hash_reg, key_hash_next;
    logic [HW-1:0]                   x_reg, x_next;
    logic [HW-1:0]                   y_reg, y_next;
    logic [HW-1:0]                   d_reg, d_next;        // remainder unit dividend
    logic [BW-1:0]                   r_reg, r_next;        // partial remainder
    logic [BW-1:0]                   bit_reg, bit_next;    // current probe bit
    logic [bfdh_pkg::PC_W-1:0]       i_reg, i_next;        // probe index
    logic [bfdh_pkg::CNT_W-1:0]      count_reg, count_next;
    logic                            hit_reg, hit_next;
    logic [AW-1:0]                   clr_addr_reg, clr_addr_next;
    logic                            clr_report_reg, clr_report_next;

    logic [bfdh_pkg::FB_W-1:0]       filter_bytes_reg;
    logic [bfdh_pkg::PC_W-1:0]       probe_count_reg;

    logic                            out_valid_reg, out_valid_next;
    bfdh_pkg::req_t                  out_op_reg, out_op_next;
    logic                            out_hit_reg, out_hit_next;

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic                 req_xfer;
    logic                 out_free;
    logic [bfdh_pkg::NB_W-1:0] nbytes;
    logic [BW:0]          store_bits;

    assign req.ready = (state_reg == bfdh_pkg::ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // filter_bytes of 0 acts as 1; above the store size saturates
    always_comb
    begin
        if (filter_bytes_reg == '0)
        begin
            nbytes = bfdh_pkg::NB_W'(1);
        end
        else if (32'(filter_bytes_reg) > bfdh_pkg::MAX_FILTER_BYTES)
        begin
            nbytes = bfdh_pkg::NB_W'(bfdh_pkg::MAX_FILTER_BYTES);
        end
        else
        begin
            nbytes = bfdh_pkg::NB_W'(filter_bytes_reg);
        end
    end

    assign store_bits = (BW + 1)'({nbytes, 3'b000});

    // ------------------------------------------------------------------
    // Shared 64-bit adder: djb2 step (h*33 = (h<<5)+h) and probe sums
    // ------------------------------------------------------------------
    logic [HW-1:0] add_a, add_b, add_sum;

    always_comb
    begin
        add_a = key_hash_reg << 5;
        add_b = key_hash_reg;
        case (state_reg)
            bfdh_pkg::ST_SALT:
            begin
                add_a = y_reg << 5;
                add_b = y_reg;
            end
            bfdh_pkg::ST_MOD_LOAD:
            begin
                case (mod_sel_reg)
                    bfdh_pkg::MS_X:
                    begin
                        add_a = x_reg;
                        add_b = y_reg;
                    end
                    bfdh_pkg::MS_Y:
                    begin
                        add_a = y_reg;
                        add_b = HW'(i_reg);
                    end
                    default:
                    begin
                        add_a = x_reg;
                        add_b = '0;
                    end
                endcase
            end
            default:
            begin
                add_a = key_hash_reg << 5;
                add_b = key_hash_reg;
            end
        endcase
    end

    assign add_sum = add_a + add_b;

    // ------------------------------------------------------------------
    // Remainder step: shift in one dividend bit, compare and subtract N
    // ------------------------------------------------------------------
    logic [BW:0]   rem_trial;
    logic [BW:0]   rem_diff;
    logic [BW-1:0] rem_step;

    assign rem_trial = {r_reg, d_reg[HW-1]};
    assign rem_diff  = rem_trial - store_bits;
    assign rem_step  = (rem_trial >= store_bits) ? rem_diff[BW-1:0] : rem_trial[BW-1:0];

    // Short pass is enough once x and y are already reduced (after probe 0)
    logic mod_full;
    assign mod_full = (i_reg == '0);

    // ------------------------------------------------------------------
    // Bit store
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic [AW-1:0]     probe_addr;
    logic [7:0]        ram_rdata;
    logic [7:0]        probe_mask;
    logic              probe_set;
    logic              last_probe;

    assign probe_addr = bit_reg[BW-1:3];
    assign probe_mask = 8'd1 << bit_reg[2:0];
    assign probe_set  = |(ram_rdata & probe_mask);
    assign last_probe = (i_reg == probe_count_reg - bfdh_pkg::PC_W'(1));

    bfdh_ram #(
        .WIDTH (8),
        .DEPTH (bfdh_pkg::MAX_FILTER_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (probe_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfdh_pkg::ST_IDLE:
            begin
                if (req_xfer)
                begin
                    case (req.req_type)
                        bfdh_pkg::REQ_LOOKUP, bfdh_pkg::REQ_INSERT:
                        begin
                            if (req.last_byte)
                            begin
                                state_next = bfdh_pkg::ST_SALT;
                            end
                        end
                        bfdh_pkg::REQ_CLEAR:
                        begin
                            state_next = bfdh_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = bfdh_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bfdh_pkg::ST_SALT:
            begin
                if (count_reg == bfdh_pkg::CNT_W'(bfdh_pkg::SALT_LEN - 1))
                begin
                    state_next = (probe_count_reg == '0) ? bfdh_pkg::ST_EMIT
                                                         : bfdh_pkg::ST_MOD_LOAD;
                end
            end
            bfdh_pkg::ST_MOD_LOAD:
            begin
                state_next = bfdh_pkg::ST_MOD_RUN;
            end
            bfdh_pkg::ST_MOD_RUN:
            begin
                if (count_reg == '0)
                begin
                    state_next = (mod_sel_reg == bfdh_pkg::MS_X) ? bfdh_pkg::ST_MOD_LOAD
                                                                 : bfdh_pkg::ST_PROBE_RD;
                end
            end
            bfdh_pkg::ST_PROBE_RD:
            begin
                state_next = bfdh_pkg::ST_PROBE_CHK;
            end
            bfdh_pkg::ST_PROBE_CHK:
            begin
                if ((op_reg == bfdh_pkg::REQ_LOOKUP && !probe_set) || last_probe)
                begin
                    state_next = bfdh_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = bfdh_pkg::ST_MOD_LOAD;
                end
            end
            bfdh_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = bfdh_pkg::ST_IDLE;
                end
            end
            bfdh_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(bfdh_pkg::MAX_FILTER_BYTES - 1))
                begin
                    state_next = clr_report_reg ? bfdh_pkg::ST_EMIT : bfdh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfdh_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    logic [HW-1:0] key_fold;

    assign key_fold = req.has_byte ? (add_sum ^ HW'(req.key_byte)) : key_hash_reg;

    always_comb
    begin
        key_hash_next   = key_hash_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        d_next          = d_reg;
        r_next          = r_reg;
        bit_next        = bit_reg;
        i_next          = i_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        op_next         = op_reg;
        mod_sel_next    = mod_sel_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        ram_we          = 1'b0;
        ram_waddr       = probe_addr;
        ram_wdata       = ram_rdata | probe_mask;

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_op_next     = out_op_reg;
        out_hit_next    = out_hit_reg;

        case (state_reg)
            bfdh_pkg::ST_IDLE:
            begin
                if (req_xfer)
                begin
                    case (req.req_type)
                        bfdh_pkg::REQ_LOOKUP, bfdh_pkg::REQ_INSERT:
                        begin
                            if (req.last_byte)
                            begin
                                x_next        = key_fold;
                                y_next        = key_fold;
                                op_next       = bfdh_pkg::req_t'(req.req_type);
                                key_hash_next = bfdh_pkg::HASH_SEED;
                                count_next    = '0;
                            end
                            else
                            begin
                                key_hash_next = key_fold;
                            end
                        end
                        bfdh_pkg::REQ_CLEAR:
                        begin
                            key_hash_next   = bfdh_pkg::HASH_SEED;
                            op_next         = bfdh_pkg::REQ_CLEAR;
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                        end
                        default:
                        begin
                            key_hash_next = key_hash_reg;
                        end
                    endcase
                end
            end
            bfdh_pkg::ST_SALT:
            begin
                y_next     = add_sum ^ HW'(bfdh_pkg::salt_byte(count_reg[3:0]));
                count_next = count_reg + bfdh_pkg::CNT_W'(1);
                i_next       = '0;
                mod_sel_next = bfdh_pkg::MS_BIT;
                hit_next     = 1'b1;
            end
            bfdh_pkg::ST_MOD_LOAD:
            begin
                r_next = '0;
                if (mod_full)
                begin
                    d_next     = add_sum;
                    count_next = bfdh_pkg::CNT_W'(bfdh_pkg::FULL_STEPS - 1);
                end
                else
                begin
                    d_next     = add_sum << bfdh_pkg::LOAD_SHIFT;
                    count_next = bfdh_pkg::CNT_W'(bfdh_pkg::SHORT_STEPS - 1);
                end
            end
            bfdh_pkg::ST_MOD_RUN:
            begin
                r_next     = rem_step;
                d_next     = d_reg << 1;
                count_next = count_reg - bfdh_pkg::CNT_W'(1);
                if (count_reg == '0)
                begin
                    case (mod_sel_reg)
                        bfdh_pkg::MS_X:
                        begin
                            x_next       = HW'(rem_step);
                            mod_sel_next = bfdh_pkg::MS_Y;
                        end
                        bfdh_pkg::MS_Y:
                        begin
                            y_next   = HW'(rem_step);
                            i_next   = i_reg + bfdh_pkg::PC_W'(1);
                            bit_next = x_reg[BW-1:0];   // x already below N
                        end
                        default:
                        begin
                            bit_next = rem_step;
                        end
                    endcase
                end
            end
            bfdh_pkg::ST_PROBE_CHK:
            begin
                ram_we       = (op_reg == bfdh_pkg::REQ_INSERT);
                mod_sel_next = bfdh_pkg::MS_X;
                if (op_reg == bfdh_pkg::REQ_LOOKUP && !probe_set)
                begin
                    hit_next = 1'b0;
                end
            end
            bfdh_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_op_next     = op_reg;
                    out_hit_next    = (op_reg == bfdh_pkg::REQ_LOOKUP) && hit_reg;
                    clr_report_next = 1'b0;
                end
            end
            bfdh_pkg::ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.done_op       = out_op_reg;
    assign rsp.maybe_present = out_hit_reg;

    // ------------------------------------------------------------------
    // Control registers; reset starts the clearing sweep
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bfdh_pkg::ST_CLEAR;
            key_hash_reg     <= bfdh_pkg::HASH_SEED;
            clr_addr_reg     <= '0;
            clr_report_reg   <= 1'b0;
            count_reg        <= '0;
            i_reg            <= '0;
            mod_sel_reg      <= bfdh_pkg::MS_BIT;
            op_reg           <= bfdh_pkg::REQ_LOOKUP;
            hit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_op_reg       <= bfdh_pkg::REQ_LOOKUP;
            out_hit_reg      <= 1'b0;
            filter_bytes_reg <= bfdh_pkg::FB_W'(bfdh_pkg::MAX_FILTER_BYTES);
            probe_count_reg  <= bfdh_pkg::PC_W'(7);
        end
        else
        begin
            state_reg      <= state_next;
            key_hash_reg   <= key_hash_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            count_reg      <= count_next;
            i_reg          <= i_next;
            mod_sel_reg    <= mod_sel_next;
            op_reg         <= op_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
            out_op_reg     <= out_op_next;
            out_hit_reg    <= out_hit_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    bfdh_pkg::CFG_FILTER_BYTES: filter_bytes_reg <= cfg_data;
                    bfdh_pkg::CFG_PROBE_COUNT:  probe_count_reg  <= cfg_data[bfdh_pkg::PC_W-1:0];
                    default:                    probe_count_reg  <= probe_count_reg;
                endcase
            end
        end
    end

    // Hash and remainder datapath, no reset
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

endmodule

`default_nettype wire

// ===== design/bfdh_checker.sv =====
// Port-level assertions for the Bloom filter core, with the bind that attaches them.
// Depends on bfdh_pkg and bloom_filter_djb2_double_hash_core.
`default_nettype none

module bfdh_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic [bfdh_pkg::REQ_W-1:0] req_type,
    input wire logic                       last_byte,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire logic [bfdh_pkg::REQ_W-1:0] done_op,
    input wire logic                       maybe_present
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(done_op) && $stable(maybe_present))
        else $error("result changed while stalled");

    // Only lookups report presence, and the unused code never completes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (done_op == bfdh_pkg::REQ_LOOKUP || !maybe_present)
                      && (done_op == bfdh_pkg::REQ_LOOKUP || done_op == bfdh_pkg::REQ_INSERT
                          || done_op == bfdh_pkg::REQ_CLEAR))
        else $error("bad result fields");

    // Starting an operation or a clear drops ready on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready
        && (req_type == bfdh_pkg::REQ_CLEAR
            || (last_byte && (req_type == bfdh_pkg::REQ_LOOKUP
                              || req_type == bfdh_pkg::REQ_INSERT)))
        |=> !req_ready)
        else $error("ready held high after operation start");

    // Store is being cleared once reset has been seen at an edge
    assert property (@(posedge clk) !rst_n |=> !req_ready)
        else $error("ready high during reset");

endmodule

bind bloom_filter_djb2_double_hash_core bfdh_checker u_bfdh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_type      (req.req_type),
    .last_byte     (req.last_byte),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .done_op       (rsp.done_op),
    .maybe_present (rsp.maybe_present)
);

`default_nettype wire

// ===== tb/bloom_filter_djb2_double_hash_core_tb.sv =====
// Self-checking bench for bloom_filter_djb2_double_hash_core: key streams, clears and config phases.
// A shadow Bloom filter predicts every operation result and checks each response transfer.
// Depends on bfdh_pkg, bfdh_req_if / bfdh_rsp_if and the design sources.

module bloom_filter_djb2_double_hash_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // req_type 3 has no package name; the block must drop it silently
    localparam logic [bfdh_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Cycles to let the block settle after the last result before a config write / end
    localparam int PAUSE_CYCLES = 32;

    typedef struct packed {
        logic [bfdh_pkg::REQ_W-1:0] op;
        logic                       hit;
    } op_result_t;

    // Shadow copy of the filter: bit store, running key hash and both registers.
    class bloom_filter_shadow;
        logic [7:0]                  store [bfdh_pkg::MAX_FILTER_BYTES];
        logic [bfdh_pkg::HASH_W-1:0] key_hash;
        logic [bfdh_pkg::FB_W-1:0]   filter_bytes;
        logic [bfdh_pkg::PC_W-1:0]   probe_count;
        op_result_t                  pending_ops [$];
        int unsigned                 mismatches;

        function new();
            wipe();
            key_hash     = bfdh_pkg::HASH_SEED;
            filter_bytes = 14'd8192;
            probe_count  = 8'd7;
            mismatches   = 0;
        endfunction

        function void wipe();
            foreach (store[k])
                store[k] = 8'h00;
        endfunction

        function logic [bfdh_pkg::HASH_W-1:0] djb2_fold(input logic [bfdh_pkg::HASH_W-1:0] h,
                                                        input logic [7:0] b);
            return ((h << 5) + h) ^ {{(bfdh_pkg::HASH_W-8){1'b0}}, b};
        endfunction

        // Test (lookup) or set (insert) the probe bits of hash x; returns 1 when all were set
        function logic probe_key(input logic [bfdh_pkg::HASH_W-1:0] x, input logic do_insert);
            logic [8*13-1:0]             salt_text;
            logic [7:0]                  sb;
            logic [bfdh_pkg::HASH_W-1:0] y;
            logic [bfdh_pkg::HASH_W-1:0] nbits;
            logic [bfdh_pkg::HASH_W-1:0] bitpos;
            logic [bfdh_pkg::HASH_W-1:0] i;
            int                          nbytes;
            salt_text = "saltygoodness";
            nbytes = (filter_bytes == 0) ? 1 :
                     (filter_bytes > bfdh_pkg::MAX_FILTER_BYTES) ? bfdh_pkg::MAX_FILTER_BYTES
                                                                 : int'(filter_bytes);
            nbits = 64'(8 * nbytes);
            y = x;
            // salt string plus its terminating NUL
            for (int k = 0; k < 14; k++)
            begin
                sb = (k < 13) ? salt_text[8*(12-k) +: 8] : 8'h00;
                y = djb2_fold(y, sb);
            end
            for (i = 0; i < probe_count; i++)
            begin
                bitpos = x % nbits;
                if (do_insert)
                    store[bitpos >> 3][bitpos[2:0]] = 1'b1;
                else if (!store[bitpos >> 3][bitpos[2:0]])
                    return 1'b0;
                x = (x + y) % nbits;
                y = (y + i) % nbits;
            end
            return 1'b1;
        endfunction

        function void write_reg(input bfdh_pkg::cfg_idx_t idx,
                                input logic [bfdh_pkg::CFG_DATA_W-1:0] value);
            if (idx == bfdh_pkg::CFG_FILTER_BYTES)
                filter_bytes = value;
            else
                probe_count = value[bfdh_pkg::PC_W-1:0];
        endfunction

        // Called on every accepted request transfer
        function void take_request(input logic [bfdh_pkg::REQ_W-1:0] rt, input logic [7:0] kb,
                                   input logic hb, input logic lb);
            op_result_t r;
            case (rt)
                bfdh_pkg::REQ_CLEAR:
                begin
                    wipe();
                    key_hash = bfdh_pkg::HASH_SEED;
                    r.op  = bfdh_pkg::REQ_CLEAR;
                    r.hit = 1'b0;
                    pending_ops.push_back(r);
                end
                bfdh_pkg::REQ_LOOKUP, bfdh_pkg::REQ_INSERT:
                begin
                    if (hb)
                        key_hash = djb2_fold(key_hash, kb);
                    if (lb)
                    begin
                        r.hit = probe_key(key_hash, rt == bfdh_pkg::REQ_INSERT);
                        if (rt != bfdh_pkg::REQ_LOOKUP)
                            r.hit = 1'b0;
                        r.op = rt;
                        key_hash = bfdh_pkg::HASH_SEED;
                        pending_ops.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        // Called on every accepted response transfer
        function void match_result(input logic [bfdh_pkg::REQ_W-1:0] op, input logic hit);
            op_result_t want;
            if (pending_ops.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: done_op=%0d maybe_present=%0b",
                             $realtime, op, hit);
                return;
            end
            want = pending_ops.pop_front();
            if (op !== want.op || hit !== want.hit)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] result mismatch: done_op exp %0d got %0d, ",
                              "maybe_present exp %0b got %0b"},
                             $realtime, want.op, op, want.hit, hit);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                            cfg_wr_en;
    logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data;

    bfdh_req_if req_ch ();
    bfdh_rsp_if rsp_ch ();

    bloom_filter_djb2_double_hash_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bloom_filter_shadow shadow = new();

    // Idle mix: percent of cycles the sender holds off / the receiver drops ready
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned items_sent;

    // Keys reused so lookups find earlier inserts
    logic [7:0] key_pool [16][8];
    int         key_pool_len [16];
    int         pool_fill;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Response side: ready redrawn each falling edge per the current stall rate
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Response monitor: sample at the rising edge, pre-update values
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow.match_result(rsp_ch.done_op, rsp_ch.maybe_present);
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #200ms;
        $display("** bloom_filter_djb2_double_hash_core: FAILED **");
        $finish;
    end

    // One request transfer. Entered and left just after a falling edge; valid stays
    // high between back-to-back items so it is never lowered and raised in one step.
    task automatic send_req(input logic [bfdh_pkg::REQ_W-1:0] rt, input logic [7:0] kb,
                            input logic hb, input logic lb);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rt;
        req_ch.key_byte  <= kb;
        req_ch.has_byte  <= hb;
        req_ch.last_byte <= lb;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        shadow.take_request(rt, kb, hb, lb);
        if (rt != REQ_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Wait for every predicted result, then let the sequencer go quiet
    task automatic drain_results();
        while (shadow.pending_ops.size() != 0)
            @(negedge clk);
        repeat (PAUSE_CYCLES) @(negedge clk);
    endtask

    // Both registers written on consecutive cycles while the block is idle
    task automatic set_config(input logic [bfdh_pkg::CFG_DATA_W-1:0] fb,
                              input logic [bfdh_pkg::PC_W-1:0] pc);
        req_ch.valid <= 1'b0;
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= bfdh_pkg::CFG_FILTER_BYTES;
        cfg_data  <= fb;
        shadow.write_reg(bfdh_pkg::CFG_FILTER_BYTES, fb);
        @(negedge clk);
        cfg_index <= bfdh_pkg::CFG_PROBE_COUNT;
        cfg_data  <= bfdh_pkg::CFG_DATA_W'(pc);
        shadow.write_reg(bfdh_pkg::CFG_PROBE_COUNT, bfdh_pkg::CFG_DATA_W'(pc));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // One key: byte transfers with random non-final types, occasional byte-less
    // fillers, and clears that cut the key short; final transfer picks the op.
    task automatic send_key(input logic [7:0] key [8], input int len,
                            input logic [bfdh_pkg::REQ_W-1:0] op, input int clear_permille);
        logic [bfdh_pkg::REQ_W-1:0] rt;
        for (int j = 0; j < len; j++)
        begin
            if ($urandom_range(999) < clear_permille)
                send_req(bfdh_pkg::REQ_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
            if ($urandom_range(99) < 5)
                send_req($urandom_range(1) ? bfdh_pkg::REQ_INSERT : bfdh_pkg::REQ_LOOKUP,
                         8'($urandom), 1'b0, 1'b0);
            rt = $urandom_range(1) ? bfdh_pkg::REQ_INSERT : bfdh_pkg::REQ_LOOKUP;
            if (j == len - 1 && $urandom_range(99) >= 15)
            begin
                send_req(op, key[j], 1'b1, 1'b1);
                return;
            end
            send_req(rt, key[j], 1'b1, 1'b0);
        end
        // empty key, or a byte-less closing transfer
        send_req(op, 8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic run_random(input int n_items, input int max_len, input int clear_permille);
        logic [7:0]                 key [8];
        logic [bfdh_pkg::REQ_W-1:0] op;
        int                         len;
        int                         slot;
        int unsigned                stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            // rotate idle mix every hundred transfers
            case ((items_sent / 100) % 4)
                0:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_gap_pct   = 49;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 49;
                end
                default:
                begin
                    send_gap_pct   = 19;
                    recv_stall_pct = 19;
                end
            endcase
            if ($urandom_range(99) < 3)
            begin
                send_req(REQ_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
                continue;
            end
            if (pool_fill > 0 && $urandom_range(1))
            begin
                slot = $urandom_range(pool_fill - 1);
                key  = key_pool[slot];
                len  = (key_pool_len[slot] > max_len) ? max_len : key_pool_len[slot];
            end
            else
            begin
                len = $urandom_range(max_len);
                foreach (key[j])
                    key[j] = 8'($urandom);
                if (pool_fill < 16)
                begin
                    slot      = pool_fill;
                    pool_fill = pool_fill + 1;
                end
                else
                begin
                    slot = $urandom_range(15);
                end
                key_pool[slot]     = key;
                key_pool_len[slot] = len;
            end
            op = $urandom_range(1) ? bfdh_pkg::REQ_INSERT : bfdh_pkg::REQ_LOOKUP;
            send_key(key, len, op, clear_permille);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = bfdh_pkg::CFG_FILTER_BYTES;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = bfdh_pkg::REQ_LOOKUP;
        req_ch.key_byte  = 8'h00;
        req_ch.has_byte  = 1'b0;
        req_ch.last_byte = 1'b0;
        send_gap_pct     = 0;
        recv_stall_pct   = 0;
        items_sent       = 0;
        pool_fill        = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at reset config (8192 bytes, 7 probes).
        // The post-reset RAM sweep just holds ready low; send_req waits it out.
        send_req(bfdh_pkg::REQ_LOOKUP, 8'h00, 1'b0, 1'b1);   // empty key on empty store: miss
        send_req(bfdh_pkg::REQ_INSERT, 8'hFF, 1'b0, 1'b1);   // insert empty key, byte not used
        send_req(bfdh_pkg::REQ_LOOKUP, 8'hFF, 1'b0, 1'b1);   // empty key now present
        send_req(bfdh_pkg::REQ_INSERT, 8'hFF, 1'b1, 1'b0);
        send_req(bfdh_pkg::REQ_LOOKUP, 8'h00, 1'b1, 1'b0);   // type of a non-final byte is irrelevant
        send_req(bfdh_pkg::REQ_INSERT, 8'hA5, 1'b1, 1'b1);
        send_req(bfdh_pkg::REQ_INSERT, 8'hFF, 1'b1, 1'b0);
        send_req(bfdh_pkg::REQ_INSERT, 8'h00, 1'b1, 1'b0);
        send_req(bfdh_pkg::REQ_LOOKUP, 8'h3C, 1'b0, 1'b0);   // filler, no hash change
        send_req(bfdh_pkg::REQ_LOOKUP, 8'hA5, 1'b1, 1'b1);   // same key: hit
        send_req(bfdh_pkg::REQ_LOOKUP, 8'hFF, 1'b1, 1'b0);
        send_req(bfdh_pkg::REQ_LOOKUP, 8'h00, 1'b1, 1'b0);
        send_req(bfdh_pkg::REQ_LOOKUP, 8'h5A, 1'b1, 1'b1);   // different last byte
        send_req(REQ_UNUSED,           8'hFF, 1'b1, 1'b1);   // unused code: dropped
        send_req(bfdh_pkg::REQ_LOOKUP, 8'h80, 1'b1, 1'b0);   // partial key ...
        send_req(bfdh_pkg::REQ_CLEAR,  8'h80, 1'b1, 1'b1);   // ... discarded by clear
        send_req(bfdh_pkg::REQ_LOOKUP, 8'hFF, 1'b0, 1'b1);   // empty key gone after clear
        send_req(bfdh_pkg::REQ_INSERT, 8'h01, 1'b1, 1'b1);
        send_req(bfdh_pkg::REQ_CLEAR,  8'h00, 1'b0, 1'b0);   // clear ignores has/last
        send_req(bfdh_pkg::REQ_LOOKUP, 8'h01, 1'b1, 1'b1);   // miss after clear

        // Smallest filter, no probes: every lookup hits
        set_config(14'd1, 8'd0);
        run_random(150, 6, 5);

        // Zero size treated as one byte; the 8-bit store fills up fast
        set_config(14'd0, 8'd3);
        run_random(250, 6, 5);

        // Oversized filter saturates; longest probe chain, few keys
        set_config(14'h3FFF, 8'd255);
        run_random(24, 3, 0);

        set_config(14'd37, 8'd12);
        run_random(600, 8, 6);

        set_config(14'd8192, 8'd1);
        run_random(300, 8, 6);

        set_config(14'($urandom_range(64, 1)), 8'($urandom_range(20, 2)));
        run_random(650, 8, 6);

        req_ch.valid <= 1'b0;
        drain_results();

        if (shadow.mismatches == 0 && shadow.pending_ops.size() == 0)
            $display("** bloom_filter_djb2_double_hash_core: PASSED **");
        else
            $display("** bloom_filter_djb2_double_hash_core: FAILED **");
        $finish;
    end

endmodule
